FILE: src/assert_macros.svh
// assertion macros used by the checker file
// depends on clk and rst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tbi_pkg.sv
// shared types and constants for the tetrahedron barycentric point test
// no dependencies
package tbi_pkg;

  // coordinate and weight formats
  localparam int CB        = 20;            // coordinate bits
  localparam int WF        = 16;            // weight fraction bits
  localparam int OW        = 24;            // output weight width
  localparam int VTX_W     = 60;            // vertex register width
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int EW  = CB + 1;              // edge vector component
  localparam int PW  = 2 * EW;              // edge product
  localparam int CW  = PW + 1;              // cross product component
  localparam int DW  = EW + CW;             // dot product term
  localparam int NW  = DW + 4;              // determinant and numerators
  localparam int QB  = OW;                  // quotient bits
  localparam int RW  = NW + WF + QB + 2;    // divider remainder

  // pipeline depths
  localparam int GEOM_LAT = 6;
  localparam int DIV_LAT  = QB + 1;
  localparam int LAT      = GEOM_LAT + DIV_LAT;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] point_x;
    logic signed [CB-1:0] point_y;
    logic signed [CB-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] weight_a;
    logic signed [OW-1:0] weight_b;
    logic signed [OW-1:0] weight_c;
    logic signed [OW-1:0] weight_d;
    logic                 inside_res;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } flags_t;

  typedef struct packed {
    logic [NW-1:0] mag;
    logic          neg;
  } num_t;

  // numerators in order a, b, c, d at index 0..3
  typedef struct packed {
    logic [NW-1:0] mag_det;
    num_t [3:0]    num;
    flags_t        flags;
  } geom_res_t;

endpackage

FILE: src/tbi_geom.sv
// edge vectors, cross and triple products, sign and magnitude of the numerators
// depends on tbi_pkg
module tbi_geom import tbi_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [VTX_W-1:0]   vtx_a,
  input  logic [VTX_W-1:0]   vtx_b,
  input  logic [VTX_W-1:0]   vtx_c,
  input  logic [VTX_W-1:0]   vtx_d,
  input  in_t                pt,
  output geom_res_t          res
);

  function automatic logic signed [EW-1:0] sext(input logic [CB-1:0] v);
    return {v[CB-1], v};
  endfunction

  function automatic logic signed [EW-1:0] coord(input logic [VTX_W-1:0] v, input int idx);
    return sext(v[idx*CB +: CB]);
  endfunction

  // stage 1: edge vectors
  logic signed [EW-1:0] ab_r [3];
  logic signed [EW-1:0] ac_r [3];
  logic signed [EW-1:0] ad_r [3];
  logic signed [EW-1:0] ap_r [3];
  logic signed [EW-1:0] p_c  [3];

  assign p_c[0] = sext(pt.point_x[CB-1:0]);
  assign p_c[1] = sext(pt.point_y[CB-1:0]);
  assign p_c[2] = sext(pt.point_z[CB-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab_r[i] <= coord(vtx_b, i) - coord(vtx_a, i);
        ac_r[i] <= coord(vtx_c, i) - coord(vtx_a, i);
        ad_r[i] <= coord(vtx_d, i) - coord(vtx_a, i);
        ap_r[i] <= p_c[i] - coord(vtx_a, i);
      end
    end
  end

  // stage 2: partial products of the crosses ac x ad, ad x ab, ab x ac
  logic signed [EW-1:0] cu_c [3][3];
  logic signed [EW-1:0] cv_c [3][3];
  logic signed [PW-1:0] pp_r [3][3][2];
  logic signed [EW-1:0] ab2_r [3];
  logic signed [EW-1:0] ap2_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cu_c[0][k] = ac_r[k];
      cv_c[0][k] = ad_r[k];
      cu_c[1][k] = ad_r[k];
      cv_c[1][k] = ab_r[k];
      cu_c[2][k] = ab_r[k];
      cv_c[2][k] = ac_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          pp_r[c][k][0] <= cu_c[c][(k+1)%3] * cv_c[c][(k+2)%3];
          pp_r[c][k][1] <= cu_c[c][(k+2)%3] * cv_c[c][(k+1)%3];
        end
      end
      ab2_r <= ab_r;
      ap2_r <= ap_r;
    end
  end

  // stage 3: cross product components
  logic signed [CW-1:0] x_r [3][3];
  logic signed [EW-1:0] ab3_r [3];
  logic signed [EW-1:0] ap3_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          x_r[c][k] <= CW'(pp_r[c][k][0]) - CW'(pp_r[c][k][1]);
        end
      end
      ab3_r <= ab2_r;
      ap3_r <= ap2_r;
    end
  end

  // stage 4: dot product terms for det, nb, nc, nd
  logic signed [DW-1:0] dp_r [4][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dp_r[0][k] <= ab3_r[k] * x_r[0][k];
        dp_r[1][k] <= ap3_r[k] * x_r[0][k];
        dp_r[2][k] <= ap3_r[k] * x_r[1][k];
        dp_r[3][k] <= ap3_r[k] * x_r[2][k];
      end
    end
  end

  // stage 5: triple products
  logic signed [NW-1:0] sum_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        sum_r[j] <= NW'(dp_r[j][0]) + NW'(dp_r[j][1]) + NW'(dp_r[j][2]);
      end
    end
  end

  // stage 6: first numerator, signs, magnitudes and flags
  logic signed [NW-1:0] n_c [4];
  logic                 nonneg_c [4];
  geom_res_t            res_nxt;
  geom_res_t            res_r;

  always_comb begin
    n_c[0] = sum_r[0] - sum_r[1] - sum_r[2] - sum_r[3];
    n_c[1] = sum_r[1];
    n_c[2] = sum_r[2];
    n_c[3] = sum_r[3];
    res_nxt.flags.degenerate = (sum_r[0] == '0);
    res_nxt.mag_det = sum_r[0][NW-1] ? NW'(-sum_r[0]) : NW'(sum_r[0]);
    for (int j = 0; j < 4; j++) begin
      nonneg_c[j] = (n_c[j] == '0) || (n_c[j][NW-1] == sum_r[0][NW-1]);
      res_nxt.num[j].neg = n_c[j][NW-1] ^ sum_r[0][NW-1];
      res_nxt.num[j].mag = n_c[j][NW-1] ? NW'(-n_c[j]) : NW'(n_c[j]);
    end
    res_nxt.flags.inside_res = !res_nxt.flags.degenerate && nonneg_c[0] && nonneg_c[1]
                               && nonneg_c[2] && nonneg_c[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: src/tbi_div.sv
// pipelined restoring divider: rounded, saturated Q weight from numerator and determinant
// depends on tbi_pkg
module tbi_div import tbi_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  num_t                 num,
  input  logic [NW-1:0]        mag_d,
  output logic signed [OW-1:0] weight
);

  logic [RW-1:0] rem_r [DIV_LAT];
  logic [RW-1:0] dd_r  [DIV_LAT];
  logic [QB-1:0] q_r   [DIV_LAT];
  logic          neg_r [DIV_LAT];
  logic          ovf_r [DIV_LAT];

  // setup: n2 = 2|N| * 2^WF + |D|, divisor 2|D|, overflow past quotient width
  logic [RW-1:0] n2_c;
  logic [RW-1:0] dd_c;

  assign n2_c = (RW'(num.mag) << (WF + 1)) + RW'(mag_d);
  assign dd_c = RW'(mag_d) << 1;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n2_c;
      dd_r[0]  <= dd_c;
      q_r[0]   <= '0;
      neg_r[0] <= num.neg;
      ovf_r[0] <= (n2_c >= (dd_c << QB));
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    localparam int BIT = QB - k;
    logic [RW-1:0] trial_c;
    logic          ge_c;

    assign trial_c = dd_r[k-1] << BIT;
    assign ge_c    = (rem_r[k-1] >= trial_c);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]      <= ge_c ? (rem_r[k-1] - trial_c) : rem_r[k-1];
        dd_r[k]       <= dd_r[k-1];
        q_r[k]        <= q_r[k-1] | (QB'(ge_c) << BIT);
        neg_r[k]      <= neg_r[k-1];
        ovf_r[k]      <= ovf_r[k-1];
      end
    end
  end

  // saturate to the signed output range
  localparam logic [QB-1:0] NEG_LIM = QB'(1) << (OW - 1);
  localparam logic [QB-1:0] POS_LIM = NEG_LIM - QB'(1);

  logic [QB-1:0] mag_c;

  always_comb begin
    if (neg_r[DIV_LAT-1]) begin
      mag_c  = (ovf_r[DIV_LAT-1] || q_r[DIV_LAT-1] > NEG_LIM) ? NEG_LIM : q_r[DIV_LAT-1];
      weight = OW'(~mag_c + QB'(1));
    end else begin
      mag_c  = (ovf_r[DIV_LAT-1] || q_r[DIV_LAT-1] > POS_LIM) ? POS_LIM : q_r[DIV_LAT-1];
      weight = OW'(mag_c);
    end
  end

endmodule

FILE: src/tetrahedron_barycentric_inside_top.sv
// Tetrahedron point test: takes one query point per clock unless the output
// is held, and returns four barycentric weights in signed Q8.16 plus inside
// and degenerate flags. A transaction passes six geometry stages (edges, cross
// products, triple products), then a 25-stage divider (a setup stage, then one
// quotient bit per stage for all four weights in parallel), then the output
// register. A held result stalls the whole pipeline, input included.
// Vertex registers must be written while no transaction is in flight.
// depends on tbi_pkg, tbi_geom, tbi_div
module tetrahedron_barycentric_inside_top import tbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [VTX_W-1:0]      cfg_wdata
);

  // vertex registers
  logic [VTX_W-1:0] vtx_a_r, vtx_b_r, vtx_c_r, vtx_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_a_r <= '0;
      vtx_b_r <= '0;
      vtx_c_r <= '0;
      vtx_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VERTEX_A: vtx_a_r <= cfg_wdata;
        REG_VERTEX_B: vtx_b_r <= cfg_wdata;
        REG_VERTEX_C: vtx_c_r <= cfg_wdata;
        REG_VERTEX_D: vtx_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the output is held
  logic vld_r [LAT];
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // geometry front end
  geom_res_t geo;

  tbi_geom u_geom (
    .clk   (clk),
    .en    (adv),
    .vtx_a (vtx_a_r),
    .vtx_b (vtx_b_r),
    .vtx_c (vtx_c_r),
    .vtx_d (vtx_d_r),
    .pt    (in_data),
    .res   (geo)
  );

  // four dividers
  logic signed [OW-1:0] w_c [4];

  for (genvar j = 0; j < 4; j++) begin : g_div
    tbi_div u_div (
      .clk    (clk),
      .en     (adv),
      .num    (geo.num[j]),
      .mag_d  (geo.mag_det),
      .weight (w_c[j])
    );
  end

  // flags ride alongside the divider stages
  flags_t flg_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_r[0] <= geo.flags;
      for (int i = 1; i < DIV_LAT; i++) flg_r[i] <= flg_r[i-1];
    end
  end

  // output register, degenerate forces zero weights
  out_t out_data_nxt;
  out_t out_data_r;

  always_comb begin
    out_data_nxt.degenerate = flg_r[DIV_LAT-1].degenerate;
    out_data_nxt.inside_res = flg_r[DIV_LAT-1].inside_res;
    if (flg_r[DIV_LAT-1].degenerate) begin
      out_data_nxt.weight_a = '0;
      out_data_nxt.weight_b = '0;
      out_data_nxt.weight_c = '0;
      out_data_nxt.weight_d = '0;
    end else begin
      out_data_nxt.weight_a = w_c[0];
      out_data_nxt.weight_b = w_c[1];
      out_data_nxt.weight_c = w_c[2];
      out_data_nxt.weight_d = w_c[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/tbi_checker.sv
// port-level checks for the tetrahedron point test, bound to the top level
// depends on tbi_pkg and assert_macros.svh
`include "assert_macros.svh"

module tbi_checker import tbi_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result transaction holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // input side never blocks while the output register is empty
  `ASSERT_CLK(a_ready_free, !out_valid |-> in_ready, "input stalled with empty output")

  // degenerate results carry zero weights and no inside flag
  `ASSERT_CLK(a_degen_zero, out_valid && out_data.degenerate |-> out_data.weight_a == 0 && out_data.weight_b == 0 && out_data.weight_c == 0 && out_data.weight_d == 0 && !out_data.inside_res, "degenerate result with weights")

  // inside implies no negative weight
  `ASSERT_CLK(a_inside_sign, out_valid && out_data.inside_res |-> !out_data.weight_a[23] && !out_data.weight_b[23] && !out_data.weight_c[23] && !out_data.weight_d[23], "inside with negative weight")

endmodule

bind tetrahedron_barycentric_inside_top tbi_checker u_tbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/tetrahedron_barycentric_inside_top_test.sv
// self-checking bench for the tetrahedron barycentric point test block
// drives points and vertex writes, predicts weights and flags internally
// depends on tbi_pkg and tetrahedron_barycentric_inside_top
module tetrahedron_barycentric_inside_top_test;
  import tbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 250;
  localparam logic signed [23:0] W_ONE  = 24'sd65536;
  localparam logic signed [23:0] W_HALF = 24'sd32768;
  localparam logic signed [23:0] W_QTR  = 24'sd16384;
  localparam logic signed [23:0] W_PMAX = 24'sd8388607;
  localparam logic signed [23:0] W_NMAX = -24'sd8388608;
  localparam int CMAX = 524287;
  localparam int CMIN = -524288;

  typedef enum logic { ROW_CFG, ROW_POINT } row_kind_e;
  typedef longint vec3_t [3];
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [VTX_W-1:0]      wdata;
    in_t                   pt;
    bit                    typed;
    out_t                  res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VTX_W-1:0]     cfg_wdata;

  logic [VTX_W-1:0] vertex_reg [4];
  out_t weights_q [$];
  int   n_err, n_sent, n_done, cyc;
  row_t dir_rows [$];

  tetrahedron_barycentric_inside_top dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tetrahedron_barycentric_inside_top_test failed");
      $finish;
    end
  end

  // coordinate k of a packed vertex, sign extended
  function automatic longint coord(logic [VTX_W-1:0] v, int k);
    return longint'($signed(v[k*CB +: CB]));
  endfunction

  function automatic logic [VTX_W-1:0] pack_vtx(int x, int y, int z);
    return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
  endfunction

  function automatic in_t mk_point(int x, int y, int z);
    in_t p;
    p.point_x = x[CB-1:0];
    p.point_y = y[CB-1:0];
    p.point_z = z[CB-1:0];
    return p;
  endfunction

  // u . (v x w), exact
  function automatic logic signed [127:0] triple_prod(vec3_t u, vec3_t v, vec3_t w);
    longint cx, cy, cz;
    logic signed [127:0] t;
    cx = v[1] * w[2] - v[2] * w[1];
    cy = v[2] * w[0] - v[0] * w[2];
    cz = v[0] * w[1] - v[1] * w[0];
    t = u[0] * cx + u[1] * cy + u[2] * cz;
    return t;
  endfunction

  // num / det in Q8.16, round half away from zero, saturate
  function automatic logic signed [23:0] ratio_q816(logic signed [127:0] num,
                                                    logic signed [127:0] det);
    logic [127:0] an, ad, q;
    logic neg;
    if (num == 0) return '0;
    neg = num[127] ^ det[127];
    an = num[127] ? -num : num;
    ad = det[127] ? -det : det;
    q = ((an << (WF + 1)) + ad) / (ad << 1);
    if (neg) begin
      if (q > 128'd8388608) q = 128'd8388608;
      return 24'(-q);
    end
    if (q > 128'd8388607) q = 128'd8388607;
    return 24'(q);
  endfunction

  function automatic bit same_side(logic signed [127:0] num, logic signed [127:0] det);
    return (num == 0) || (num[127] == det[127]);
  endfunction

  function automatic out_t predict_barycentric(in_t p);
    vec3_t a, ab, ac, ad, ap;
    logic signed [127:0] det, nb, nc, nd, na;
    out_t r;
    for (int k = 0; k < 3; k++) begin
      a[k]  = coord(vertex_reg[0], k);
      ab[k] = coord(vertex_reg[1], k) - a[k];
      ac[k] = coord(vertex_reg[2], k) - a[k];
      ad[k] = coord(vertex_reg[3], k) - a[k];
    end
    ap[0] = longint'(p.point_x) - a[0];
    ap[1] = longint'(p.point_y) - a[1];
    ap[2] = longint'(p.point_z) - a[2];
    r = '0;
    det = triple_prod(ab, ac, ad);
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nb = triple_prod(ap, ac, ad);
    nc = triple_prod(ab, ap, ad);
    nd = triple_prod(ab, ac, ap);
    na = det - nb - nc - nd;
    r.weight_a = ratio_q816(na, det);
    r.weight_b = ratio_q816(nb, det);
    r.weight_c = ratio_q816(nc, det);
    r.weight_d = ratio_q816(nd, det);
    r.inside_res = same_side(na, det) && same_side(nb, det) &&
                   same_side(nc, det) && same_side(nd, det);
    return r;
  endfunction

  // wait for the pipeline to drain, then write one vertex
  task automatic write_vertex(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] v);
    in_valid <= 1'b0;
    while (weights_q.size() != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    vertex_reg[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one point, with random gaps ahead of it
  task automatic send_point(in_t p, bit typed, out_t res);
    bit quiet;
    quiet = (n_sent >= 700 && n_sent < 1000);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    weights_q.push_back(typed ? res : predict_barycentric(p));
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  function automatic int rand_coord(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] v);
    row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.idx = idx; r.wdata = v;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_pt(in_t p, bit typed, out_t res);
    row_t r;
    r = '{kind: ROW_POINT, default: '0};
    r.pt = p; r.typed = typed; r.res = res;
    dir_rows.push_back(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_done++;
      if (weights_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        n_err++;
      end else begin
        e = weights_q.pop_front();
        if (out_data.weight_a !== e.weight_a) begin
          $display("%0t: weight_a exp %0d act %0d", $time, e.weight_a, out_data.weight_a);
          n_err++;
        end
        if (out_data.weight_b !== e.weight_b) begin
          $display("%0t: weight_b exp %0d act %0d", $time, e.weight_b, out_data.weight_b);
          n_err++;
        end
        if (out_data.weight_c !== e.weight_c) begin
          $display("%0t: weight_c exp %0d act %0d", $time, e.weight_c, out_data.weight_c);
          n_err++;
        end
        if (out_data.weight_d !== e.weight_d) begin
          $display("%0t: weight_d exp %0d act %0d", $time, e.weight_d, out_data.weight_d);
          n_err++;
        end
        if (out_data.inside_res !== e.inside_res) begin
          $display("%0t: inside_res exp %0b act %0b", $time, e.inside_res,
                   out_data.inside_res);
          n_err++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $display("%0t: degenerate exp %0b act %0b", $time, e.degenerate,
                   out_data.degenerate);
          n_err++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold, a quiet stretch
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!held && n_done >= 300) begin
        held = 1;
        hold = 200;
        out_ready <= 1'b0;
      end else if (n_done >= 700 && n_done < 1000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 10);
      end
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int span, x0, y0, z0;
    out_t dg, r;
    n_err = 0; n_sent = 0; n_done = 0;
    in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    for (int k = 0; k < 4; k++) vertex_reg[k] = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    dg = '0;
    dg.degenerate = 1'b1;
    add_pt(mk_point(0, 0, 0), 1, dg);
    add_pt(mk_point(CMIN, CMAX, -1), 1, dg);
    add_cfg(REG_VERTEX_A, pack_vtx(0, 0, 0));
    add_cfg(REG_VERTEX_B, pack_vtx(1024, 0, 0));
    add_cfg(REG_VERTEX_C, pack_vtx(0, 1024, 0));
    add_cfg(REG_VERTEX_D, pack_vtx(0, 0, 1024));
    r = '{W_ONE, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0};
    add_pt(mk_point(0, 0, 0), 1, r);
    r = '{24'sd0, W_HALF, W_HALF, 24'sd0, 1'b1, 1'b0};
    add_pt(mk_point(512, 512, 0), 1, r);
    r = '{W_QTR, W_QTR, W_QTR, W_QTR, 1'b1, 1'b0};
    add_pt(mk_point(256, 256, 256), 1, r);
    r = '{24'sd131072, -W_ONE, 24'sd0, 24'sd0, 1'b0, 1'b0};
    add_pt(mk_point(-1024, 0, 0), 1, r);
    r = '{W_NMAX, W_PMAX, 24'sd0, 24'sd0, 1'b0, 1'b0};
    add_pt(mk_point(CMAX, 0, 0), 1, r);
    r = '{W_PMAX, W_NMAX, W_NMAX, W_NMAX, 1'b0, 1'b0};
    add_pt(mk_point(CMIN, CMIN, CMIN), 1, r);
    add_pt(mk_point(1023, 1, 0), 0, dg);
    // coplanar corners
    add_cfg(REG_VERTEX_D, pack_vtx(300, 300, 0));
    add_pt(mk_point(5, 5, 5), 1, dg);
    // corners at the coordinate extremes
    add_cfg(REG_VERTEX_A, pack_vtx(CMIN, CMIN, CMIN));
    add_cfg(REG_VERTEX_B, pack_vtx(CMAX, CMIN, CMIN));
    add_cfg(REG_VERTEX_C, pack_vtx(CMIN, CMAX, CMIN));
    add_cfg(REG_VERTEX_D, pack_vtx(CMIN, CMIN, CMAX));
    add_pt(mk_point(CMAX, CMAX, CMAX), 0, dg);
    add_pt(mk_point(CMIN, CMIN, CMIN), 0, dg);
    add_pt(mk_point(0, 0, 0), 0, dg);
    add_pt(mk_point(-1, -1, CMAX), 0, dg);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_vertex(dir_rows[i].idx, dir_rows[i].wdata);
      else send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, each with fresh corners
    for (int ph = 0; ph < N_PHASES; ph++) begin
      span = (ph % 3 == 0) ? 2000 : (ph % 3 == 1) ? CMAX : 100;
      x0 = rand_coord(span); y0 = rand_coord(span); z0 = rand_coord(span);
      write_vertex(REG_VERTEX_A, pack_vtx(x0, y0, z0));
      write_vertex(REG_VERTEX_B, pack_vtx(rand_coord(span), rand_coord(span),
                                          rand_coord(span)));
      write_vertex(REG_VERTEX_C, pack_vtx(rand_coord(span), rand_coord(span),
                                          rand_coord(span)));
      // one phase with a repeated corner, one with full random bits
      if (ph == 4) write_vertex(REG_VERTEX_D, vertex_reg[1]);
      else if (ph == 1) write_vertex(REG_VERTEX_D, VTX_W'({$urandom(), $urandom()}));
      else write_vertex(REG_VERTEX_D, pack_vtx(rand_coord(span), rand_coord(span),
                                               rand_coord(span)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 20)
          send_point(in_t'(VTX_W'({$urandom(), $urandom()})), 0, dg);
        else
          send_point(mk_point(rand_coord(span), rand_coord(span), rand_coord(span)),
                     0, dg);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (weights_q.size() != 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);
    if (n_err == 0) $display("tetrahedron_barycentric_inside_top_test passed");
    else $display("tetrahedron_barycentric_inside_top_test failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/tbi_pkg.sv
src/tbi_geom.sv
src/tbi_div.sv
src/tetrahedron_barycentric_inside_top.sv
src/tbi_checker.sv
dv/tetrahedron_barycentric_inside_top_test.sv
